/* src/itil_pkg.sv */
// ----------------------------------------------------------------------------
// itil_pkg
// shared types and codes for the ipv4 trie insert / lookup block
// ----------------------------------------------------------------------------
package itil_pkg;

  // slot kinds held in the top two bits of a node store entry
  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_LINK  = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_MISS     = 3'd2;
  localparam logic [2:0] ST_CONFLICT = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam int unsigned LEVELS     = 4;
  localparam int unsigned BYTE_BITS  = 8;
  localparam logic [1:0]  LAST_LEVEL = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic       clr_step;   // write one empty slot of the clearing pass
    logic       in_ready;   // input channel open
    logic       rd;         // read slot at current node and level
    logic       descend;    // follow link just read
    logic       link_wr;    // write fresh link, move to fresh node
    logic       value_wr;   // write value at leaf level
    logic       res_set;    // latch pending result
    logic [2:0] res_status;
    logic       out_load;   // move pending result to output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic       in_valid;
    logic       out_free;
    logic       lookup;
    logic [1:0] kind;
    logic       link_ok;
    logic       fits;
    logic [1:0] level;
  } sts_t;

endpackage

/* src/itil_if.sv */
// ----------------------------------------------------------------------------
// itil_in_if / itil_out_if
// valid / ready channels carrying request and result words
// ----------------------------------------------------------------------------
interface itil_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] address;
  logic [15:0] entry_value;

  modport source (output valid, output action, output address, output entry_value,
                  input ready);
  modport sink   (input valid, input action, input address, input entry_value,
                  output ready);
endinterface

interface itil_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] found_value;

  modport source (output valid, output status, output found_value, input ready);
  modport sink   (input valid, input status, input found_value, output ready);
endinterface

/* src/ipv4_trie_insert_lookup.sv */
// ----------------------------------------------------------------------------
// ipv4_trie_insert_lookup
// four-level 256-way trie mapping ipv4 addresses to short values
// ----------------------------------------------------------------------------
// usage
//   in_i carries request words: action (insert or look up), address and
//   entry_value. out_o carries one result word per request: status
//   and found_value (zero unless the request is a lookup hit).
//   one request is worked at a time through the single node memory; each
//   trie level visited takes a read state and an evaluate state, and each
//   fresh node on insert takes a link write state.
//   lookup: read and evaluate for each level visited, then the result handoff.
//   insert: walk as above, plus one write per fresh link and one value write.
//   after reset the node store is swept to empty, one slot a cycle, and no
//   request is taken then.
//   the result sits in an output register: a new request is taken while it
//   waits, but a second result holds back until the receiver takes the first.
//   the node pool counter restarts at one at reset (root is node zero).
// ----------------------------------------------------------------------------
module ipv4_trie_insert_lookup #(
  parameter int unsigned NODE_COUNT = 256,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itil_in_if.sink    in_i,
  itil_out_if.source out_o
);
  import itil_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, walk, commit and result handoff
  itil_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // datapath: node store, pool counter, walk and result registers
  itil_dp #(
    .NODE_COUNT(NODE_COUNT),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .out_o (out_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );

endmodule

/* src/itil_ram.sv */
// ----------------------------------------------------------------------------
// itil_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module itil_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/itil_ctrl.sv */
// ----------------------------------------------------------------------------
// itil_ctrl
// sequencer for clearing pass, trie walk, commit and result handoff
// ----------------------------------------------------------------------------
module itil_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  itil_pkg::sts_t sts_i,
  output itil_pkg::cmd_t cmd_o
);
  import itil_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_LINK  = 3'd4;
  localparam logic [2:0] S_VALUE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       last;

  assign last = (sts_i.level == LAST_LEVEL);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (sts_i.lookup) begin
          if (sts_i.kind == KIND_VALUE) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_HIT;
            state_d          = S_DONE;
          end else if (sts_i.kind == KIND_LINK && !last && sts_i.link_ok) begin
            cmd_o.descend = 1'b1;
            state_d       = S_READ;
          end else begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_MISS;
            state_d          = S_DONE;
          end
        end else begin
          if (sts_i.kind == KIND_VALUE ||
              (sts_i.kind == KIND_LINK && (last || !sts_i.link_ok))) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_CONFLICT;
            state_d          = S_DONE;
          end else if (sts_i.kind == KIND_LINK) begin
            cmd_o.descend = 1'b1;
            state_d       = S_READ;
          end else if (!sts_i.fits) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_FULL;
            state_d          = S_DONE;
          end else if (last) begin
            state_d = S_VALUE;
          end else begin
            state_d = S_LINK;
          end
        end
      end
      S_LINK: begin
        cmd_o.link_wr = 1'b1;
        if (sts_i.level == 2'd2) state_d = S_VALUE;
      end
      S_VALUE: begin
        cmd_o.value_wr   = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_INSERTED;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/itil_dp.sv */
// ----------------------------------------------------------------------------
// itil_dp
// request and walk registers, node pool counter, node store, result register
// ----------------------------------------------------------------------------
module itil_dp #(
  parameter int unsigned NODE_COUNT = 256,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  itil_in_if.sink        in_i,
  itil_out_if.source     out_o,
  input  itil_pkg::cmd_t cmd_i,
  output itil_pkg::sts_t sts_o
);
  import itil_pkg::*;

  localparam int unsigned NB    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned FB    = $clog2(NODE_COUNT + 1);
  localparam int unsigned DW    = (VALUE_BITS > NB) ? VALUE_BITS : NB;
  localparam int unsigned DEPTH = NODE_COUNT * (2 ** BYTE_BITS);
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = DW + 2;

  logic                  act_q;
  logic [31:0]           addr_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [1:0]            level_q;
  logic [NB-1:0]         node_q;
  logic [FB-1:0]         free_q;
  logic [AW-1:0]         clr_q;
  logic [2:0]            res_status_q;
  logic [15:0]           res_value_q;
  logic                  out_valid_q;
  logic [2:0]            out_status_q;
  logic [15:0]           out_value_q;

  logic [7:0]    cur_byte;
  logic [AW-1:0] slot_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [RW-1:0] wdata;
  logic [RW-1:0] rdata;
  logic [1:0]    rd_kind;
  logic [DW-1:0] rd_data;
  logic [FB:0]   need_end;
  logic          accept;

  always_comb begin
    case (level_q)
      2'd0:    cur_byte = addr_q[31:24];
      2'd1:    cur_byte = addr_q[23:16];
      2'd2:    cur_byte = addr_q[15:8];
      default: cur_byte = addr_q[7:0];
    endcase
  end

  assign slot_addr = AW'({node_q, cur_byte});
  assign rd_kind   = rdata[RW-1 -: 2];
  assign rd_data   = rdata[DW-1:0];

  // write port: clearing pass, fresh link, or leaf value
  always_comb begin
    we    = cmd_i.clr_step | cmd_i.link_wr | cmd_i.value_wr;
    waddr = slot_addr;
    wdata = {KIND_VALUE, DW'(val_q)};
    if (cmd_i.clr_step) begin
      waddr = clr_q;
      wdata = {KIND_EMPTY, DW'(0)};
    end else if (cmd_i.link_wr) begin
      wdata = {KIND_LINK, DW'(free_q)};
    end
  end

  itil_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(slot_addr),
    .rdata_o(rdata)
  );

  assign accept   = cmd_i.in_ready & in_i.valid;
  assign need_end = (FB + 1)'(free_q) + (FB + 1)'(LAST_LEVEL - level_q);

  assign sts_o.clr_done = (clr_q == AW'(DEPTH - 1));
  assign sts_o.in_valid = in_i.valid;
  assign sts_o.out_free = !out_valid_q || out_o.ready;
  assign sts_o.lookup   = act_q;
  assign sts_o.kind     = rd_kind;
  assign sts_o.link_ok  = (32'(rd_data) < 32'(NODE_COUNT));
  assign sts_o.fits     = (32'(need_end) <= 32'(NODE_COUNT));
  assign sts_o.level    = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      node_q      <= '0;
      free_q      <= FB'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + AW'(1);
      if (accept) begin
        level_q <= '0;
        node_q  <= '0;
      end
      if (cmd_i.descend) begin
        node_q  <= rd_data[NB-1:0];
        level_q <= level_q + 2'd1;
      end
      if (cmd_i.link_wr) begin
        node_q  <= free_q[NB-1:0];
        free_q  <= free_q + FB'(1);
        level_q <= level_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q  <= in_i.action;
      addr_q <= in_i.address;
      val_q  <= VALUE_BITS'(in_i.entry_value);
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= (cmd_i.res_status == ST_HIT) ?
                      16'(rd_data[VALUE_BITS-1:0]) : 16'd0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  assign in_i.ready        = cmd_i.in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.found_value = out_value_q;

endmodule

/* tb/sv/ipv4_trie_insert_lookup_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_trie_insert_lookup_tb
// self-checking bench: request words go in from a queue at random pace, a
// trie model in the bench predicts each result word, and the result channel
// is checked in order under random receiver stalls
// ----------------------------------------------------------------------------
module ipv4_trie_insert_lookup_tb;
  import itil_pkg::*;

  // trie geometry, matching the block's default parameters
  localparam int unsigned NODES      = 256;
  localparam int unsigned FANOUT     = 256;
  localparam int unsigned SLOT_TOTAL = NODES * FANOUT;

  // request opcodes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam int unsigned RANDOM_WORDS = 1430;
  localparam int unsigned PACE_SPAN    = 40;   // words per idle-pattern draw
  localparam int unsigned MAX_WAIT     = 16;
  localparam int unsigned TAIL_CYCLES  = 30;   // longest walk plus margin

  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [15:0] entry_value;
  } trie_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] found_value;
  } trie_res_t;

  // a staged request may ask the sender to hold it until the block is drained
  typedef struct packed {
    trie_req_t req;
    logic      hold_till_drained;
  } staged_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  itil_in_if  req_if ();
  itil_out_if res_if ();

  ipv4_trie_insert_lookup i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // trie model: slot kind and payload (link node or stored value), pool count
  // --------------------------------------------------------------------------
  logic [1:0]  slot_kind [SLOT_TOTAL];
  logic [15:0] slot_data [SLOT_TOTAL];
  int unsigned pool_next;

  staged_req_t request_q [$];       // words waiting to be sent
  trie_res_t   pending_results [$]; // predicted result words, oldest first
  int unsigned mismatch_count = 0;

  // registered handshakes, read by the falling-edge processes
  logic word_taken   = 1'b0;
  logic result_taken = 1'b0;

  // walk the trie for one request, updating the model on a successful insert
  function automatic trie_res_t trie_apply(trie_req_t r);
    int unsigned node;
    int unsigned lvl;
    int unsigned slot;
    int unsigned need;
    trie_res_t   res;
    node = 0;
    res.status = ST_MISS;
    res.found_value = '0;
    if (r.action == ACT_LOOKUP) begin
      for (lvl = 0; lvl < LEVELS; lvl++) begin
        slot = node * FANOUT + r.address[(24 - 8 * lvl) +: 8];
        if (slot_kind[slot] == KIND_VALUE) begin
          res.status = ST_HIT;
          res.found_value = slot_data[slot];
          return res;
        end
        // empty slot, leaf without value, or a stray link all end in a miss
        if (slot_kind[slot] != KIND_LINK || lvl == LEVELS - 1 || slot_data[slot] >= NODES)
          return res;
        node = slot_data[slot];
      end
      return res;
    end
    // dry walk down to the first empty slot, stop on any value or stray link on the way
    for (lvl = 0; lvl < LEVELS; lvl++) begin
      slot = node * FANOUT + r.address[(24 - 8 * lvl) +: 8];
      if (slot_kind[slot] == KIND_VALUE ||
          (slot_kind[slot] == KIND_LINK && (lvl == LEVELS - 1 || slot_data[slot] >= NODES))) begin
        res.status = ST_CONFLICT;
        return res;
      end
      if (slot_kind[slot] == KIND_EMPTY)
        break;
      node = slot_data[slot];
    end
    if (lvl >= LEVELS) begin
      res.status = ST_CONFLICT;
      return res;
    end
    // fresh nodes for every level between the empty slot and the leaf
    need = LEVELS - 1 - lvl;
    if (pool_next + need > NODES) begin
      res.status = ST_FULL;
      return res;
    end
    for (; lvl < LEVELS - 1; lvl++) begin
      slot = node * FANOUT + r.address[(24 - 8 * lvl) +: 8];
      slot_kind[slot] = KIND_LINK;
      slot_data[slot] = pool_next[15:0];
      node = pool_next;
      pool_next++;
    end
    slot = node * FANOUT + r.address[7:0];
    slot_kind[slot] = KIND_VALUE;
    slot_data[slot] = r.entry_value;
    res.status = ST_INSERTED;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic queue_req(logic action, logic [31:0] address, logic [15:0] entry_value,
                           logic hold);
    staged_req_t s;
    s.req.action = action;
    s.req.address = address;
    s.req.entry_value = entry_value;
    s.hold_till_drained = hold;
    request_q.push_back(s);
  endtask

  // calm stretches give back-to-back traffic, the rest waits a random gap bounded by MAX_WAIT
  function automatic int unsigned pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // --------------------------------------------------------------------------
  // checker and predictor: outputs sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a result word always belongs to an earlier request, so check first
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result word status %0d with nothing pending",
                                    res_if.status));
        end else begin
          if (res_if.status !== pending_results[0].status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      res_if.status, pending_results[0].status));
          if (res_if.found_value !== pending_results[0].found_value)
            report_mismatch($sformatf("found_value %h, expected %h",
                                      res_if.found_value, pending_results[0].found_value));
          void'(pending_results.pop_front());
        end
      end
      if (req_if.valid && req_if.ready)
        pending_results.push_back(trie_apply({req_if.action, req_if.address,
                                              req_if.entry_value}));
    end
    word_taken   <= rst_ni && req_if.valid && req_if.ready;
    result_taken <= rst_ni && res_if.valid && res_if.ready;
  end

  // --------------------------------------------------------------------------
  // request driver: changes inputs at the falling edge
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned sent_count = 0;
  bit          send_calm = 1'b0;
  staged_req_t send_cur;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || word_taken) begin
      if (send_gap != 0) begin
        req_if.valid <= 1'b0;
        send_gap--;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].hold_till_drained && pending_results.size() != 0)) begin
        send_cur = request_q.pop_front();
        req_if.valid       <= 1'b1;
        req_if.action      <= send_cur.req.action;
        req_if.address     <= send_cur.req.address;
        req_if.entry_value <= send_cur.req.entry_value;
        if (sent_count % PACE_SPAN == 0)
          send_calm = ($urandom_range(0, 2) == 0);
        sent_count++;
        send_gap = pick_wait(send_calm);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: after each word, stall a random number of cycles
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned taken_count = 0;
  bit          take_calm = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (result_taken) begin
      if (taken_count % PACE_SPAN == 0)
        take_calm = ($urandom_range(0, 2) == 0);
      taken_count++;
      stall_left = pick_wait(take_calm);
      res_if.ready <= (stall_left == 0);
    end else if (!res_if.ready) begin
      if (stall_left > 1)
        stall_left--;
      else
        res_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0]  base;
    logic [31:0]  addr;
    logic [31:0]  inserted_q [$];
    int unsigned  pick;

    for (int s = 0; s < SLOT_TOTAL; s++) begin
      slot_kind[s] = KIND_EMPTY;
      slot_data[s] = '0;
    end
    pool_next = 1;  // node zero is the root

    // directed: empty trie, zero value, duplicates, a miss at every level,
    // all-zero and all-one addresses and values, fresh node counts 0 to 3
    queue_req(ACT_LOOKUP, 32'h0000_0000, 16'h0000, 1'b0);
    queue_req(ACT_INSERT, 32'h0000_0000, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_0000, 16'hffff, 1'b0);
    queue_req(ACT_INSERT, 32'h0000_0000, 16'hffff, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_0001, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_0100, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0001_0000, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0100_0000, 16'h0000, 1'b0);
    // pause the sender once until the block has nothing in flight
    queue_req(ACT_INSERT, 32'hffff_ffff, 16'hffff, 1'b1);
    queue_req(ACT_LOOKUP, 32'hffff_ffff, 16'h0000, 1'b0);
    queue_req(ACT_INSERT, 32'h0000_00ff, 16'h5555, 1'b0);
    queue_req(ACT_INSERT, 32'h0000_ff00, 16'haaaa, 1'b0);
    queue_req(ACT_INSERT, 32'h00ff_0000, 16'h1234, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_00ff, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h0000_ff00, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h00ff_0000, 16'h0000, 1'b0);
    queue_req(ACT_INSERT, 32'hffff_ffff, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'hffff_fffe, 16'h0000, 1'b0);
    queue_req(ACT_LOOKUP, 32'hff00_0000, 16'h0000, 1'b0);
    queue_req(ACT_INSERT, 32'h8000_0000, 16'h8000, 1'b0);
    queue_req(ACT_LOOKUP, 32'h8000_0000, 16'h0000, 1'b0);
    inserted_q.push_back(32'h0000_0000);
    inserted_q.push_back(32'hffff_ffff);
    inserted_q.push_back(32'h0000_00ff);
    inserted_q.push_back(32'h0000_ff00);
    inserted_q.push_back(32'h00ff_0000);
    inserted_q.push_back(32'h8000_0000);

    // random: mostly addresses near earlier inserts so the walk goes deep;
    // the pool runs dry part way, after which only leaf-only inserts succeed
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      base = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 3))
          0, 1: addr = base;
          2: addr = {base[31:8], 8'($urandom)};
          default: addr = $urandom;
        endcase
        queue_req(ACT_LOOKUP, addr, 16'($urandom), 1'b0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15)
          addr = base;                             // duplicate, conflict
        else if (pick < 65)
          addr = {base[31:8], 8'($urandom)};       // same leaf node
        else if (pick < 80)
          addr = {base[31:16], 16'($urandom)};     // one fresh node
        else if (pick < 90)
          addr = {base[31:24], 24'($urandom)};     // two fresh nodes
        else
          addr = $urandom;                         // up to three
        inserted_q.push_back(addr);
        queue_req(ACT_INSERT, addr, 16'($urandom_range(0, 65535)),
                  $urandom_range(0, 199) == 0);
      end
    end

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // block sweeps its store after reset, then works the queue
    while (request_q.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("ipv4_trie_insert_lookup verification clean");
    else
      $display("ipv4_trie_insert_lookup verification failed");
    $finish;
  end

  // slowest run: the store sweep plus ~1450 words, each with the longest idle gap,
  // receiver stall and busy walk; allow roughly ten times that
  initial begin
    #(15_000_000);
    $display("ipv4_trie_insert_lookup verification failed");
    $finish;
  end

endmodule
